// ----- src/amkd_pkg.sv -----
// Shared constants, types and the control program of the keypad decoder.
`timescale 1ns / 1ps
package amkd_pkg;

    localparam int SAMPLES  = 16;
    localparam int SAMPLE_W = 12;
    localparam int KEY_W    = 4;
    localparam int CNT_W    = $clog2(SAMPLES + 1);
    localparam int MID_LO   = (SAMPLES - 1) / 2;
    localparam int MID_HI   = SAMPLES / 2;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 12'h0FFF;
    localparam int LADDER_SPAN = 14;
    localparam int STEP_SIZE   = int'(SAMPLE_MAX) / LADDER_SPAN;
    localparam logic [SAMPLE_W-1:0] TOP_BOUND = 12'h0F6F;

    localparam int NUM_KEYS  = 8;
    localparam int KEY_IDX_W = $clog2(NUM_KEYS);
    localparam logic [KEY_IDX_W-1:0] LAST_KEY_IDX = KEY_IDX_W'(NUM_KEYS - 1);

    // Lower and upper bounds of each key window; both are strict.
    localparam logic [SAMPLE_W-1:0] WIN_LO [0:NUM_KEYS-1] = '{
        12'd0,
        12'(STEP_SIZE * 1),
        12'(STEP_SIZE * 3),
        12'(STEP_SIZE * 5),
        12'(STEP_SIZE * 7),
        12'(STEP_SIZE * 9),
        12'(STEP_SIZE * 11),
        12'(STEP_SIZE * 13)
    };
    localparam logic [SAMPLE_W-1:0] WIN_HI [0:NUM_KEYS-1] = '{
        12'(STEP_SIZE * 1),
        12'(STEP_SIZE * 3),
        12'(STEP_SIZE * 5),
        12'(STEP_SIZE * 7),
        12'(STEP_SIZE * 9),
        12'(STEP_SIZE * 11),
        12'(STEP_SIZE * 13),
        TOP_BOUND
    };

    typedef enum logic [1:0] {
        COND_ALWAYS   = 2'd0,
        COND_BURST    = 2'd1,
        COND_KEY      = 2'd2,
        COND_OUT_FREE = 2'd3
    } cond_t;

    typedef logic [1:0] step_t;
    localparam step_t STEP_LOAD   = 2'd0;
    localparam step_t STEP_MEDIAN = 2'd1;
    localparam step_t STEP_KEY    = 2'd2;
    localparam step_t STEP_EMIT   = 2'd3;

    typedef struct packed {
        logic  accept;
        logic  load_median;
        logic  key_test;
        logic  emit;
        cond_t cond;
        step_t on_true;
        step_t on_false;
    } uword_t;

    typedef struct packed {
        logic accept;
        logic load_median;
        logic key_test;
        logic emit;
    } ctrl_t;

    typedef struct packed {
        logic burst_done;
        logic key_done;
        logic out_free;
    } status_t;

    function automatic uword_t ucode(step_t s);
        uword_t w;
        unique case (s)
            STEP_LOAD:   w = '{1'b1, 1'b0, 1'b0, 1'b0, COND_BURST,    STEP_MEDIAN, STEP_LOAD};
            STEP_MEDIAN: w = '{1'b0, 1'b1, 1'b0, 1'b0, COND_ALWAYS,   STEP_KEY,    STEP_KEY};
            STEP_KEY:    w = '{1'b0, 1'b0, 1'b1, 1'b0, COND_KEY,      STEP_EMIT,   STEP_KEY};
            STEP_EMIT:   w = '{1'b0, 1'b0, 1'b0, 1'b1, COND_OUT_FREE, STEP_LOAD,   STEP_EMIT};
        endcase
        return w;
    endfunction

endpackage

// ----- src/amkd_if.sv -----
// Valid/ready channel interfaces for ADC samples and decoded results.
`timescale 1ns / 1ps
interface amkd_in_if;
    logic                          valid;
    logic                          ready;
    logic [amkd_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface amkd_out_if;
    logic                          valid;
    logic                          ready;
    logic [amkd_pkg::SAMPLE_W-1:0] median_value;
    logic [amkd_pkg::KEY_W-1:0]    key_code;

    modport source (output valid, output median_value, output key_code, input ready);
    modport sink (input valid, input median_value, input key_code, output ready);
endinterface

// ----- src/amkd_sequencer.sv -----
// Step counter, control program lookup and conditional jump logic.
`timescale 1ns / 1ps
module amkd_sequencer (
    input  logic              clk,
    input  logic              rst_n,
    input  amkd_pkg::status_t status,
    output amkd_pkg::ctrl_t   ctrl
);
    import amkd_pkg::*;

    step_t  step_reg;
    step_t  step_next;
    uword_t uw;
    logic   cond_met;

    assign uw   = ucode(step_reg);
    assign ctrl = '{uw.accept, uw.load_median, uw.key_test, uw.emit};

    always_comb
    begin
        unique case (uw.cond)
            COND_ALWAYS:   cond_met = 1'b1;
            COND_BURST:    cond_met = status.burst_done;
            COND_KEY:      cond_met = status.key_done;
            COND_OUT_FREE: cond_met = status.out_free;
        endcase
        step_next = cond_met ? uw.on_true : uw.on_false;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_LOAD;
        end
        else
        begin
            step_reg <= step_next;
        end
    end
endmodule

// ----- src/amkd_sort_cells.sv -----
// Row of sorted sample cells filled by parallel insertion, with the burst count.
`timescale 1ns / 1ps
module amkd_sort_cells (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          insert,
    input  logic [amkd_pkg::SAMPLE_W-1:0] sample,
    output logic                          last,
    output logic [amkd_pkg::SAMPLE_W-1:0] mid_lo,
    output logic [amkd_pkg::SAMPLE_W-1:0] mid_hi
);
    import amkd_pkg::*;

    logic [SAMPLE_W-1:0] cell_reg  [SAMPLES];
    logic [SAMPLE_W-1:0] cell_next [SAMPLES];
    logic [SAMPLES-1:0]  le;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;

    assign last   = (count_reg == CNT_W'(SAMPLES - 1));
    assign mid_lo = cell_reg[MID_LO];
    assign mid_hi = cell_reg[MID_HI];

    // Cells below the fill count hold the burst so far in ascending order.
    for (genvar i = 0; i < SAMPLES; i++)
    begin : g_cell
        assign le[i] = (CNT_W'(i) < count_reg) && (cell_reg[i] <= sample);
        if (i == 0)
        begin : g_first
            assign cell_next[i] = le[i] ? cell_reg[i] : sample;
        end
        else
        begin : g_rest
            assign cell_next[i] = le[i]     ? cell_reg[i] :
                                  le[i - 1] ? sample      : cell_reg[i - 1];
        end

        always_ff @(posedge clk)
        begin
            if (insert)
            begin
                cell_reg[i] <= cell_next[i];
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (insert)
        begin
            count_next = last ? '0 : count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end
endmodule

// ----- src/amkd_key_unit.sv -----
// Median register and the window test stepped through one key per cycle.
`timescale 1ns / 1ps
module amkd_key_unit (
    input  logic                          clk,
    input  logic                          load_median,
    input  logic                          key_test,
    input  logic [amkd_pkg::SAMPLE_W-1:0] mid_lo,
    input  logic [amkd_pkg::SAMPLE_W-1:0] mid_hi,
    output logic                          key_done,
    output logic [amkd_pkg::SAMPLE_W-1:0] median_value,
    output logic [amkd_pkg::KEY_W-1:0]    key_code
);
    import amkd_pkg::*;

    logic [SAMPLE_W-1:0]  value_reg;
    logic [KEY_IDX_W-1:0] idx_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [SAMPLE_W:0]    mid_sum;
    logic                 hit;

    assign mid_sum = {1'b0, mid_lo} + {1'b0, mid_hi};

    // The lowest window has no lower bound.
    assign hit = ((idx_reg == '0) || (value_reg > WIN_LO[idx_reg]))
                 && (value_reg < WIN_HI[idx_reg]);
    assign key_done     = hit || (idx_reg == LAST_KEY_IDX);
    assign median_value = value_reg;
    assign key_code     = key_reg;

    always_ff @(posedge clk)
    begin
        if (load_median)
        begin
            value_reg <= mid_sum[SAMPLE_W:1];
            idx_reg   <= '0;
            key_reg   <= '0;
        end
        else if (key_test)
        begin
            idx_reg <= idx_reg + KEY_IDX_W'(1);
            if (hit)
            begin
                key_reg <= KEY_W'(idx_reg) + KEY_W'(1);
            end
        end
    end
endmodule

// ----- src/adc_median_keypad_decoder.sv -----
// Top level of the resistor-ladder keypad decoder with burst median filter.
`timescale 1ns / 1ps
// Each burst of SAMPLES ADC words is sorted into a row of cells as it arrives,
// one word per cycle while the source offers one. The word that completes a
// burst starts a short control program: the median is formed from the two
// middle cells, then the key windows are tested one per cycle until one
// matches or the last is reached, then the result is handed to the output
// register. No sample is taken while those steps run. A result waiting in the
// output register does not stop the next burst from loading; only its emit
// step waits for the register.
module adc_median_keypad_decoder (
    input logic       clk,
    input logic       rst_n,
    amkd_in_if.sink   in_ch,
    amkd_out_if.source out_ch
);
    import amkd_pkg::*;

    ctrl_t               ctrl;
    status_t             status;
    logic                insert;
    logic                last;
    logic                key_done;
    logic                out_free;
    logic [SAMPLE_W-1:0] mid_lo;
    logic [SAMPLE_W-1:0] mid_hi;
    logic [SAMPLE_W-1:0] median_value;
    logic [KEY_W-1:0]    key_code;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [SAMPLE_W-1:0] out_median_reg;
    logic [KEY_W-1:0]    out_key_reg;

    assign in_ch.ready = ctrl.accept;
    assign insert      = ctrl.accept && in_ch.valid;
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign status      = '{insert && last, key_done, out_free};

    amkd_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    amkd_sort_cells u_cells (
        .clk    (clk),
        .rst_n  (rst_n),
        .insert (insert),
        .sample (in_ch.sample),
        .last   (last),
        .mid_lo (mid_lo),
        .mid_hi (mid_hi)
    );

    amkd_key_unit u_key (
        .clk          (clk),
        .load_median  (ctrl.load_median),
        .key_test     (ctrl.key_test),
        .mid_lo       (mid_lo),
        .mid_hi       (mid_hi),
        .key_done     (key_done),
        .median_value (median_value),
        .key_code     (key_code)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl.emit && out_free)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.emit && out_free)
        begin
            out_median_reg <= median_value;
            out_key_reg    <= key_code;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.median_value = out_median_reg;
    assign out_ch.key_code     = out_key_reg;
endmodule

// ----- src/amkd_checker.sv -----
// Port-level assertions for the keypad decoder and the bind that attaches them.
`timescale 1ns / 1ps
module amkd_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [amkd_pkg::SAMPLE_W-1:0] median_value,
    input logic [amkd_pkg::KEY_W-1:0]    key_code
);
    import amkd_pkg::*;

    logic [CNT_W-1:0] fill_reg;
    logic [7:0]       bursts_reg;
    logic [7:0]       results_reg;
    logic [7:0]       owed;
    logic             burst_end;
    logic             key_ok;

    assign burst_end = in_valid && in_ready && (fill_reg == CNT_W'(SAMPLES - 1));
    assign owed      = bursts_reg - results_reg;

    always_comb
    begin
        key_ok = 1'b0;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            if ((key_code == KEY_W'(k + 1))
                && ((k == 0) || (median_value > WIN_LO[k]))
                && (median_value < WIN_HI[k]))
            begin
                key_ok = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            bursts_reg  <= '0;
            results_reg <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                fill_reg <= burst_end ? '0 : fill_reg + CNT_W'(1);
            end
            if (burst_end)
            begin
                bursts_reg <= bursts_reg + 8'd1;
            end
            if (out_valid && out_ready)
            begin
                results_reg <= results_reg + 8'd1;
            end
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(median_value) && $stable(key_code))
        else $error("result word changed while stalled");

    a_no_extra_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> owed != 8'd0)
        else $error("result word without a completed burst");

    a_owed_bound: assert property (@(posedge clk) disable iff (!rst_n)
        owed <= 8'd2)
        else $error("more than two bursts waiting for results");

    a_key_window: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && key_code != '0 |-> key_ok)
        else $error("key code does not match the median window");
endmodule

bind adc_median_keypad_decoder amkd_checker u_amkd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .median_value (out_ch.median_value),
    .key_code     (out_ch.key_code)
);
